// ===== sv/sem_pkg.sv =====
// shared constants, types and state codes of the rgb sobel edge magnitude unit
`default_nettype none

package sem_pkg;

	// line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = COL_W + 1;
	localparam int DIST_W    = COL_W + 3;

	// register and field widths
	localparam int FW_W   = 11;
	localparam int FH_W   = 16;
	localparam int IDX_W  = 8;
	localparam int CFG_W  = 16;
	localparam int CH_W   = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W  = CH_W * NUM_CH;
	localparam int GRAD_W = 11;
	localparam int SUM_W  = 2 * GRAD_W;

	// reset values of the registers
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(768);

	// register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

	// input kinds
	localparam logic ACT_PIXEL = 1'b0;

	// magnitude limits: 255.5 squared rounded up
	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65281);
	localparam logic [CH_W-1:0]  CH_MAX    = CH_W'(255);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_MSTART,
		ST_MWAIT,
		ST_PUSH,
		ST_WRITE
	} sem_state_t;

endpackage

`default_nettype wire

// ===== sv/sem_line_ram.sv =====
// single port write, single port read line store with registered read data
`default_nettype none

module sem_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/sem_magnitude.sv =====
// iterative rounded square root of gx^2 + gy^2, saturated to one channel byte
`default_nettype none

module sem_magnitude
	import sem_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [GRAD_W-1:0] gx,
	input  wire logic signed [GRAD_W-1:0] gy,
	output logic                          rdy,
	output logic             [CH_W-1:0]   mag
);

	localparam logic [3:0] STEP_LAST  = 4'(CH_W);
	localparam logic [3:0] STEP_ROUND = 4'(CH_W + 1);

	logic        [3:0]       cnt_q;
	logic        [SUM_W-1:0] s_q;
	logic        [CH_W-1:0]  n_q;
	logic        [CH_W-1:0]  mag_q;
	logic                    rdy_q;
	logic signed [SUM_W-1:0] sqx;
	logic signed [SUM_W-1:0] sqy;
	logic        [SUM_W-1:0] s_d;
	logic        [2:0]       bit_idx;
	logic        [CH_W-1:0]  trial;
	logic        [2*CH_W-1:0] trial_sq;
	logic        [SUM_W-1:0] round_lim;

	// squares and their sum
	always_comb begin
		sqx = SUM_W'(gx) * SUM_W'(gx);
		sqy = SUM_W'(gy) * SUM_W'(gy);
		s_d = $unsigned(sqx) + $unsigned(sqy);
	end

	// one result bit per step, most significant first
	always_comb begin
		bit_idx  = 3'(STEP_LAST - cnt_q);
		trial    = n_q | (CH_W'(1) << bit_idx);
		trial_sq = (2*CH_W)'(trial) * (2*CH_W)'(trial);
		round_lim = SUM_W'(n_q) * SUM_W'(n_q) + SUM_W'(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rdy_q <= 1'b0;
		end else if (start) begin
			cnt_q <= 4'd1;
			rdy_q <= 1'b0;
		end else if (cnt_q == STEP_ROUND) begin
			cnt_q <= '0;
			rdy_q <= 1'b1;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= s_d;
			n_q <= '0;
		end else if (cnt_q != '0 && cnt_q <= STEP_LAST) begin
			if (SUM_W'(trial_sq) <= s_q) begin
				n_q <= trial;
			end
		end else if (cnt_q == STEP_ROUND) begin
			if (s_q >= SAT_LIMIT) begin
				mag_q <= CH_MAX;
			end else if (s_q > round_lim) begin
				mag_q <= n_q + CH_W'(1);
			end else begin
				mag_q <= n_q;
			end
		end
	end

	assign rdy = rdy_q;
	assign mag = mag_q;

endmodule

`default_nettype wire

// ===== sv/sobel_edge_magnitude_rgb_unit.sv =====
// top level: rgb sobel edge magnitude over two line stores
//
// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    tdata red,green,blue; tuser action
// m_axis    out        m_axis_tvalid/tready    tdata red,green,blue; tuser frame_end
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// a word that releases an output passes read, gradient, root and push states;
// other pixel words skip root and push. four reads of the line store port and the
// root unit's 8 bit steps set the work; an ignored drain word is taken while idle.
// reset restores the registers and clears all counters; the line stores are not cleared.
// a stalled output holds the unit before its store write; input stays off meanwhile.
`default_nettype none

module sobel_edge_magnitude_rgb_unit
	import sem_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [PIX_W-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
	input  wire logic              s_axis_tuser,  // action
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [PIX_W-1:0]  m_axis_tdata,  // red_out, green_out, blue_out
	output logic                   m_axis_tuser,  // frame_end
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	sem_state_t state_q, state_d;

	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [WID_W-1:0]  w_eff;
	logic [FH_W-1:0]   h_eff;

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [FH_W-1:0]   in_row_q, out_row_q;
	logic              draining_q;
	logic [WID_W-1:0]  dbase_q;

	pix_t              pix_q;
	logic              emit_q, wr_q, has_arr_q;
	logic [1:0]        rd_cnt_q;
	logic              rd_vld_s1;
	logic [1:0]        rd_idx_s1;

	pix_t              win_q [3][3];
	pix_t              upd_older_q, upd_newer_q;
	pix_t              evict_near_q, evict_far_q;
	logic signed [GRAD_W-1:0] gx_q [NUM_CH];
	logic signed [GRAD_W-1:0] gy_q [NUM_CH];

	logic              out_valid_q, out_last_q;
	pix_t              out_data_q;

	logic              in_acc, cfg_acc, start_item;
	logic              rd_en, mag_start, push_en, wr_en, mem_we;
	logic [COL_W-1:0]  raddr;
	pix_t              older_rdata, newer_rdata;
	logic [NUM_CH-1:0] mag_rdy;
	logic [CH_W-1:0]   mag [NUM_CH];

	logic              last_now, emit_pix, in_wrap, in_end, out_wrap;
	logic [2:0]        rowok;
	logic              colok;
	pix_t              fetch_val [3];
	logic signed [DIST_W-1:0] dcol, gap, ws;

	logic signed [GRAD_W-1:0] gx_d [NUM_CH];
	logic signed [GRAD_W-1:0] gy_d [NUM_CH];

	// effective frame size
	always_comb begin
		if (fw_q == '0) begin
			w_eff = WID_W'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(fw_q);
		end
		h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
	end

	// position tests
	always_comb begin
		out_wrap = (WID_W'(out_col_q) + WID_W'(1)) >= w_eff;
		last_now = ((17'(out_row_q) + 17'd1) >= 17'(h_eff)) && out_wrap;
		in_wrap  = (WID_W'(in_col_q) + WID_W'(1)) >= w_eff;
		in_end   = (17'(in_row_q) + 17'd1) >= 17'(h_eff);
		emit_pix = (WID_W+1)'(dbase_q) >= ((WID_W+1)'(w_eff) + (WID_W+1)'(1));
		rowok[0] = out_row_q != '0;
		rowok[1] = 1'b1;
		rowok[2] = (17'(out_row_q) + 17'd1) < 17'(h_eff);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start_item) state_d = ST_READ;
			ST_READ:   if (rd_cnt_q == 2'd3) state_d = ST_GRAD;
			ST_GRAD:   state_d = emit_q ? ST_MSTART : ST_WRITE;
			ST_MSTART: state_d = ST_MWAIT;
			ST_MWAIT:  if (&mag_rdy) state_d = ST_PUSH;
			ST_PUSH:   if (!out_valid_q || m_axis_tready) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		rd_en         = 1'b0;
		mag_start     = 1'b0;
		push_en       = 1'b0;
		wr_en         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready     = 1'b1;
				s_axis_tready = !cfg_valid;
			end
			ST_READ:   rd_en = 1'b1;
			ST_GRAD:   ;
			ST_MSTART: mag_start = 1'b1;
			ST_MWAIT:  ;
			ST_PUSH:   push_en = !out_valid_q || m_axis_tready;
			ST_WRITE:  wr_en = 1'b1;
			default:   ;
		endcase
	end

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign start_item = in_acc && (draining_q || s_axis_tuser == ACT_PIXEL);
	assign mem_we     = wr_en && wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// line stores
	assign raddr = (rd_cnt_q == 2'd3) ? in_col_q
		: out_col_q + COL_W'(rd_cnt_q) - COL_W'(1);

	sem_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_older_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (in_col_q),
		.wdata (upd_newer_q),
		.raddr (raddr),
		.rdata (older_rdata)
	);

	sem_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_newer_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (raddr),
		.rdata (newer_rdata)
	);

	// sort read data into the window by distance behind the newest pixel
	always_comb begin
		ws   = $signed(DIST_W'(w_eff));
		dcol = $signed(DIST_W'(dbase_q)) + DIST_W'(1) - $signed(DIST_W'(rd_idx_s1));
		unique case (rd_idx_s1)
			2'd0:    colok = out_col_q != '0;
			2'd2:    colok = !out_wrap;
			default: colok = 1'b1;
		endcase
		for (int i = 0; i < 3; i++) begin
			gap = dcol + ws - $signed(DIST_W'(i)) * ws;
			if (!(rowok[i] && colok)) begin
				fetch_val[i] = '0;
			end else if (gap == '0 && has_arr_q) begin
				fetch_val[i] = pix_q;
			end else if (gap >= DIST_W'(1) && gap <= ws) begin
				fetch_val[i] = newer_rdata;
			end else if (gap > ws && gap <= DIST_W'(2) * ws) begin
				fetch_val[i] = older_rdata;
			end else if (gap == DIST_W'(2) * ws + DIST_W'(1)) begin
				fetch_val[i] = evict_near_q;
			end else if (gap == DIST_W'(2) * ws + DIST_W'(2)) begin
				fetch_val[i] = evict_far_q;
			end else begin
				fetch_val[i] = '0;
			end
		end
	end

	// sobel sums per channel
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			gx_d[c] = ($signed(GRAD_W'(win_q[0][2][c*CH_W +: CH_W]))
					- $signed(GRAD_W'(win_q[0][0][c*CH_W +: CH_W])))
				+ GRAD_W'(2) * ($signed(GRAD_W'(win_q[1][2][c*CH_W +: CH_W]))
					- $signed(GRAD_W'(win_q[1][0][c*CH_W +: CH_W])))
				+ ($signed(GRAD_W'(win_q[2][2][c*CH_W +: CH_W]))
					- $signed(GRAD_W'(win_q[2][0][c*CH_W +: CH_W])));
			gy_d[c] = ($signed(GRAD_W'(win_q[2][0][c*CH_W +: CH_W]))
					+ GRAD_W'(2) * $signed(GRAD_W'(win_q[2][1][c*CH_W +: CH_W]))
					+ $signed(GRAD_W'(win_q[2][2][c*CH_W +: CH_W])))
				- ($signed(GRAD_W'(win_q[0][0][c*CH_W +: CH_W]))
					+ GRAD_W'(2) * $signed(GRAD_W'(win_q[0][1][c*CH_W +: CH_W]))
					+ $signed(GRAD_W'(win_q[0][2][c*CH_W +: CH_W])));
		end
	end

	// root units, one per channel
	for (genvar c = 0; c < NUM_CH; c++) begin : g_mag
		sem_magnitude u_mag (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mag_start),
			.gx     (gx_q[c]),
			.gy     (gy_q[c]),
			.rdy    (mag_rdy[c]),
			.mag    (mag[c])
		);
	end

	// item payload, window and gradients
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q     <= s_axis_tdata;
			has_arr_q <= !draining_q;
			wr_q      <= !draining_q;
			emit_q    <= draining_q || emit_pix;
		end
		rd_idx_s1 <= rd_cnt_q;
		if (rd_vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (rd_idx_s1 == 2'(j)) begin
						win_q[i][j] <= fetch_val[i];
					end
				end
			end
			if (rd_idx_s1 == 2'd3) begin
				upd_older_q <= older_rdata;
				upd_newer_q <= newer_rdata;
			end
		end
		if (state_q == ST_GRAD) begin
			gx_q <= gx_d;
			gy_q <= gy_d;
		end
		if (mem_we) begin
			evict_far_q  <= evict_near_q;
			evict_near_q <= upd_older_q;
		end
	end

	// read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (start_item) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int c = 0; c < NUM_CH; c++) begin
				out_data_q[c*CH_W +: CH_W] <= mag[c];
			end
			out_last_q <= last_now;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_last_q;

	// registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FW_RESET;
			fh_q       <= FH_RESET;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			draining_q <= 1'b0;
			dbase_q    <= '0;
		end else if (cfg_acc) begin
			if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					fw_q <= cfg_data[FW_W-1:0];
				end else begin
					fh_q <= cfg_data[FH_W-1:0];
				end
				in_col_q   <= '0;
				in_row_q   <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				draining_q <= 1'b0;
				dbase_q    <= '0;
			end
		end else if (wr_en) begin
			if (emit_q && last_now) begin
				// final output of the frame restarts it
				in_col_q   <= '0;
				in_row_q   <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				draining_q <= 1'b0;
				dbase_q    <= '0;
			end else begin
				if (wr_q) begin
					// pixel word
					if (in_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_end ? h_eff : in_row_q + FH_W'(1);
						if (in_end) begin
							draining_q <= 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
					if (!emit_q) begin
						dbase_q <= dbase_q + WID_W'(1);
					end
				end else begin
					dbase_q <= dbase_q - WID_W'(1);
				end
				if (emit_q) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + FH_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

`ifndef SYNTH
	// outputs never run further than one row and one pixel behind the input
	a_dbase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(WID_W+1)'(dbase_q) <= (WID_W+1)'(w_eff) + (WID_W+1)'(1))
		else $error("input to output distance exceeds one row plus one");

	// a drain only starts at the head of a row
	a_drain_col: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> (in_col_q == '0))
		else $error("draining with nonzero input column");

	// a result is loaded only once all root units have finished
	a_push_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> (&mag_rdy) && emit_q)
		else $error("result pushed before magnitude ready");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench of the rgb sobel edge magnitude unit: directed and random frames against a predictor
`default_nettype none

module tb;
	import sem_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [PIX_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [PIX_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sobel_edge_magnitude_rgb_unit u_top (.*);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} edge_px_t;

	// predictor state
	pix_t   row_old [MAX_WIDTH];
	pix_t   row_new [MAX_WIDTH];
	pix_t   evict_near, evict_far;
	int unsigned in_col, in_row, out_col, out_row;
	bit     drain_pending;
	int unsigned width_reg, height_reg;

	edge_px_t pending_edges[$];
	int     mismatch_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	longint cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned eff_w();
		if (width_reg < 1) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg < 1) ? 1 : height_reg;
	endfunction

	function automatic void restart_frame();
		in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		drain_pending = 0;
	endfunction

	function automatic pix_t window_px(int r, int c, int unsigned w, int unsigned h,
			int unsigned written, bit has_new, pix_t arriving);
		int unsigned q;
		if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return '0;
		q = r * w + c;
		if (has_new && q == written) return arriving;
		if (q < written && q + w >= written) return row_new[c];
		if (q + w < written && q + 2 * w >= written) return row_old[c];
		if (q + 2 * w + 1 == written) return evict_near;
		if (q + 2 * w + 2 == written) return evict_far;
		return '0;
	endfunction

	// rounded integer root, saturated
	function automatic logic [CH_W-1:0] grad_mag(int gx, int gy);
		int unsigned s, n, t;
		s = gx * gx + gy * gy;
		n = 0;
		if (s >= 65281) return CH_MAX;
		for (int b = 128; b != 0; b >>= 1) begin
			t = n | b;
			if (t * t <= s) n = t;
		end
		if (s > n * n + n) n++;
		return (n > 255) ? CH_MAX : n[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] chan_edge(pix_t win [3][3], int sh);
		int a [3][3];
		int gx, gy;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = (win[i][j] >> sh) & 8'hff;
		gx = (a[0][2] - a[0][0]) + 2 * (a[1][2] - a[1][0]) + (a[2][2] - a[2][0]);
		gy = (a[2][0] + 2 * a[2][1] + a[2][2]) - (a[0][0] + 2 * a[0][1] + a[0][2]);
		return grad_mag(gx, gy);
	endfunction

	function automatic edge_px_t next_edge(int unsigned w, int unsigned h, bit has_new,
			pix_t arriving);
		pix_t win [3][3];
		edge_px_t e;
		int unsigned written;
		written = in_row * w + in_col;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = window_px(int'(out_row) + i - 1, int'(out_col) + j - 1,
					w, h, written, has_new, arriving);
		e.red = chan_edge(win, 16);
		e.green = chan_edge(win, 8);
		e.blue = chan_edge(win, 0);
		e.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return e;
	endfunction

	// predict the result of one accepted word
	function automatic void predict_word(bit drain, pix_t px);
		int unsigned w, h, c;
		edge_px_t e;
		w = eff_w();
		h = eff_h();
		if (drain_pending) begin
			e = next_edge(w, h, 0, '0);
			pending_edges.push_back(e);
			if (e.frame_end) restart_frame();
			return;
		end
		if (drain) return;
		if (in_row * w + in_col >= w + 1) pending_edges.push_back(next_edge(w, h, 1, px));
		c = in_col;
		evict_far = evict_near;
		evict_near = row_old[c];
		row_old[c] = row_new[c];
		row_new[c] = px;
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
			if (in_row >= h) begin
				in_row = h;
				drain_pending = 1;
			end
		end else begin
			in_col++;
		end
	endfunction

	// valid stays high from one word to the next unless the sender idles
	task automatic send_word(bit drain, pix_t px);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= drain;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		predict_word(drain, px);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_edges.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
		else if (idx == REG_FRAME_HEIGHT) height_reg = val;
		else return;
		restart_frame();
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
	endtask

	function automatic pix_t rand_px();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return {$urandom_range(1) ? 8'hff : 8'h00, 8'h00, $urandom_range(1) ? 8'hff : 8'h00};
			default: return pix_t'($urandom());
		endcase
	endfunction

	// one whole frame, with stray drain words mixed in when noisy, followed by its drain words
	task automatic run_frame(bit noisy);
		int unsigned n;
		n = eff_w() * eff_h();
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && $urandom_range(19) == 0) send_word(1'b1, pix_t'($urandom()));
			send_word(1'b0, rand_px());
		end
		while (drain_pending) send_word($urandom_range(3) != 0, pix_t'($urandom()));
	endtask

	// result checking
	always @(posedge clk) begin
		edge_px_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata, m_axis_tuser};
			if (pending_edges.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word %h", got);
			end else begin
				want = pending_edges.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("edge mismatch: expected %h got %h", want, got);
				end
			end
		end
		m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1500000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_extremes();
		set_frame(3, 3);
		send_word(1'b1, '1);
		for (int i = 0; i < 9; i++) send_word(1'b0, (i % 2) ? '1 : '0);
		send_word(1'b0, '1);
		while (drain_pending) send_word(1'b1, '0);
	endtask

	task automatic test_small_shapes();
		set_frame(1, 1); run_frame(1);
		set_frame(4, 1); run_frame(1);
		set_frame(1, 5); run_frame(1);
		set_frame(0, 0); run_frame(0);
	endtask

	task automatic test_restart_mid_frame();
		set_frame(5, 4);
		for (int i = 0; i < 12; i++) send_word(1'b0, rand_px());
		wait_idle();
		write_reg(8'd7, 16'h1234);
		write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
		run_frame(0);
	endtask

	task automatic test_random_frames();
		int unsigned w, h;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 33 : 54) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 33 : 54) : 0;
			for (int f = 0; f < 3; f++) begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 5);
				set_frame(w, h);
				run_frame(1);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// clamped full width: run past one row and one pixel, then restart
		set_frame(2047, 2);
		for (int i = 0; i < 1028; i++) send_word(1'b0, rand_px());
		set_frame(3, 65535);
		for (int i = 0; i < 20; i++) send_word(1'b0, rand_px());
	endtask

	initial begin
		width_reg = FW_RESET;
		height_reg = FH_RESET;
		restart_frame();
		evict_near = '0;
		evict_far = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_small_shapes();
		test_restart_mid_frame();
		test_random_frames();
		wait_idle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
